// ===== src/bucketed_hash_key_table_macros.svh =====
// Assertion macros for the bucketed hash key table top level.
`ifndef BUCKETED_HASH_KEY_TABLE_MACROS_SVH
`define BUCKETED_HASH_KEY_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bht_pkg.sv =====
// Package with the field widths, codes and types of the bucketed hash key table.
`timescale 1ns / 1ps
package bht_pkg;

  // Field widths of the request and result beats.
  localparam int KEY_W        = 32;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int BUCKET_IDX_W = 4;
  localparam int WAY_IDX_W    = 3;
  localparam int TOTAL_W      = 8;

  // The bucket hash consumes the key one byte per cycle.
  localparam int HASH_DIGIT_W  = 8;
  localparam int HASH_DIGITS   = KEY_W / HASH_DIGIT_W;
  localparam int DIGIT_CNT_W   = $clog2(HASH_DIGITS);

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ABSENT   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DELETED  = 3'd4;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_DECIDE
  } bht_state_t;

  // Memory port controls from the sequencer to the store.
  typedef struct packed {
    logic rd_en;
    logic key_wr_en;
    logic row_wr_en;
  } bht_mem_ctl_t;

endpackage

// ===== src/bht_if.sv =====
// Request and result channel interfaces of the bucketed hash key table.
`timescale 1ns / 1ps

// Request channel: mode and key.
interface bht_req_if;
  logic                       valid;
  logic                       ready;
  logic [bht_pkg::MODE_W-1:0] mode;
  logic [bht_pkg::KEY_W-1:0]  key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

// Result channel: status, location and entry total.
interface bht_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [bht_pkg::STATUS_W-1:0]     status;
  logic [bht_pkg::BUCKET_IDX_W-1:0] bucket_index;
  logic [bht_pkg::WAY_IDX_W-1:0]    way_index;
  logic [bht_pkg::TOTAL_W-1:0]      entry_total;

  modport source (output valid, output status, output bucket_index, output way_index,
                  output entry_total, input ready);
  modport sink (input valid, input status, input bucket_index, input way_index,
                input entry_total, output ready);
endinterface

// ===== src/bucketed_hash_key_table.sv =====
// Top level of the bucketed hash key table: sequencer, way scan and result register.
`timescale 1ns / 1ps
`include "bucketed_hash_key_table_macros.svh"
// Usage:
// Requests arrive on in_bus (mode and 32-bit key) with a valid/ready handshake;
// each request beat yields exactly one result beat on out_bus carrying the
// status, bucket index, way index and the entry total after the request.
// The bucket is the key modulo NUM_BUCKETS, computed by a shared remainder
// unit one key byte at a time. One comparator then walks the ways of
// that bucket, one way per cycle, stopping at the first match, so a request
// scans k ways with 1 <= k <= WAYS.
// The sequencer takes one request at a time, through hash, scan and decide
// steps, and returns to idle as it loads the result into the output register,
// ready for the next request.
// After reset the valid rows are swept clear, one bucket per cycle, and
// in_bus.ready stays low until the sweep is done.
// A result waits in the output register while out_bus.ready is low; a new
// request may be accepted and processed meanwhile, and it holds in its final
// step until the waiting result beat has been taken.
module bucketed_hash_key_table #(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  bht_req_if.sink   in_bus,
  bht_rsp_if.source out_bus
);
  import bht_pkg::*;

  localparam int BKW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS = NUM_BUCKETS * WAYS;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam logic [WW-1:0] LAST_WAY = WW'(WAYS - 1);

  bht_state_t state_r;
  bht_state_t state_nxt;

  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;

  logic [WW-1:0] scan_way_r;
  logic          hit_r;
  logic [WW-1:0] hit_way_r;
  logic          free_found_r;
  logic [WW-1:0] free_way_r;

  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [BUCKET_IDX_W-1:0] out_bucket_r;
  logic [WAY_IDX_W-1:0]    out_way_r;
  logic [TOTAL_W-1:0]      out_total_r;

  logic               in_ready;
  logic               in_fire;
  logic               mod_start;
  logic               mod_done;
  logic [BKW-1:0]     bucket;
  bht_mem_ctl_t       mem_ctl;
  logic [WW-1:0]      rd_way;
  logic [KEY_W-1:0]   key_rd;
  logic [WAYS-1:0]    row_rd;
  logic               clr_busy;

  logic               cur_valid;
  logic               cur_match;
  logic               scan_stop;
  logic               out_free;
  logic               commit;

  logic [STATUS_W-1:0] status_d;
  logic [WW-1:0]       way_d;
  logic [WW-1:0]       wr_way_d;
  logic [WAYS-1:0]     wr_row_d;
  logic                key_wr_d;
  logic                row_wr_d;

  // Shared remainder unit for the bucket hash.
  bht_mod_unit #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (in_bus.key),
    .done  (mod_done),
    .rem   (bucket)
  );

  // Key and valid row storage.
  bht_store #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS(WAYS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .bucket   (bucket),
    .rd_way   (rd_way),
    .wr_way   (wr_way_d),
    .wr_key   (key_r),
    .wr_row   (wr_row_d),
    .key_rd   (key_rd),
    .row_rd   (row_rd),
    .clr_busy (clr_busy)
  );

  // Handshake and compare of the way under scan.
  assign in_ready  = (state_r == S_IDLE) && !clr_busy;
  assign in_fire   = in_bus.valid && in_ready;
  assign cur_valid = row_rd[scan_way_r];
  assign cur_match = cur_valid && (key_rd == key_r);
  assign scan_stop = cur_match || (scan_way_r == LAST_WAY);
  assign out_free  = !out_valid_r || out_bus.ready;
  assign commit    = (state_r == S_DECIDE) && out_free;

  // Request outcome from the scan results.
  always_comb begin
    status_d  = STAT_ABSENT;
    way_d     = '0;
    wr_way_d  = hit_way_r;
    wr_row_d  = row_rd;
    key_wr_d  = 1'b0;
    row_wr_d  = 1'b0;
    count_nxt = count_r;
    unique case (mode_r)
      MODE_CREATE: begin
        if (hit_r) begin
          status_d = STAT_FOUND;
          way_d    = hit_way_r;
        end else if (free_found_r) begin
          status_d  = STAT_INSERTED;
          way_d     = free_way_r;
          wr_way_d  = free_way_r;
          wr_row_d  = row_rd | (WAYS'(1) << free_way_r);
          key_wr_d  = 1'b1;
          row_wr_d  = 1'b1;
          count_nxt = count_r + CW'(1);
        end else begin
          status_d = STAT_FULL;
        end
      end
      MODE_DELETE: begin
        if (hit_r) begin
          status_d = STAT_DELETED;
          way_d    = hit_way_r;
          wr_row_d = row_rd & ~(WAYS'(1) << hit_way_r);
          row_wr_d = 1'b1;
          if (count_r != '0) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      default: begin
        // Get, and the unused mode code, only look.
        if (hit_r) begin
          status_d = STAT_FOUND;
          way_d    = hit_way_r;
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_HASH;
      S_HASH:   if (mod_done) state_nxt = S_SCAN;
      S_SCAN:   if (scan_stop) state_nxt = S_DECIDE;
      S_DECIDE: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    mod_start         = 1'b0;
    mem_ctl.rd_en     = 1'b0;
    mem_ctl.key_wr_en = 1'b0;
    mem_ctl.row_wr_en = 1'b0;
    rd_way            = '0;
    unique case (state_r)
      S_IDLE: begin
        mod_start = in_fire;
      end
      S_HASH: begin
        mem_ctl.rd_en = mod_done;
      end
      S_SCAN: begin
        mem_ctl.rd_en = !scan_stop;
        rd_way        = scan_way_r + WW'(1);
      end
      S_DECIDE: begin
        mem_ctl.key_wr_en = commit && key_wr_d;
        mem_ctl.row_wr_en = commit && row_wr_d;
      end
      default: begin
        mod_start = 1'b0;
      end
    endcase
  end

  // Control registers: state, entry count, scan bookkeeping, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      scan_way_r   <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_HASH && mod_done) begin
        scan_way_r   <= '0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        scan_way_r <= scan_way_r + WW'(1);
        if (cur_match) begin
          hit_r <= 1'b1;
        end
        if (!cur_valid && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: request capture, scan positions, result fields.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_bus.mode;
      key_r  <= in_bus.key;
    end
    if (state_r == S_SCAN) begin
      if (cur_match) begin
        hit_way_r <= scan_way_r;
      end
      if (!cur_valid && !free_found_r) begin
        free_way_r <= scan_way_r;
      end
    end
    if (commit) begin
      out_status_r <= status_d;
      out_bucket_r <= BUCKET_IDX_W'(bucket);
      out_way_r    <= WAY_IDX_W'(way_d);
      out_total_r  <= TOTAL_W'(count_nxt);
    end
  end

  assign in_bus.ready         = in_ready;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.bucket_index = out_bucket_r;
  assign out_bus.way_index    = out_way_r;
  assign out_bus.entry_total  = out_total_r;

  // Checks on the sequencer and the bookkeeping.
  `BHT_ASSERT_SAME(a_done_in_hash, clk, rst_n, mod_done, state_r == S_HASH,
                   "bucket hash finished outside the hash step")
  `BHT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(SLOTS),
                   "entry count exceeds the table size")
  `BHT_ASSERT_NEXT(a_insert_count, clk, rst_n, commit && status_d == STAT_INSERTED,
                   count_r == $past(count_r) + CW'(1),
                   "insert did not raise the entry count")
  `BHT_ASSERT_SAME(a_miss_way_zero, clk, rst_n,
                   out_valid_r && (out_status_r == STAT_ABSENT || out_status_r == STAT_FULL),
                   out_way_r == '0, "miss or full result with a nonzero way")

endmodule

// ===== src/bht_mod_unit.sv =====
// Iterative key modulo bucket count unit, one key byte per cycle.
`timescale 1ns / 1ps
module bht_mod_unit #(
  parameter int NUM_BUCKETS = 16,
  localparam int RW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bht_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [RW-1:0]             rem
);
  import bht_pkg::*;

  localparam int TW = RW + 1;
  localparam logic [TW-1:0] MODULUS = TW'(NUM_BUCKETS);
  localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(HASH_DIGITS - 1);

  logic [KEY_W-1:0]       key_sh_r;
  logic [RW-1:0]          rem_r;
  logic [RW-1:0]          rem_nxt;
  logic [DIGIT_CNT_W-1:0] digit_cnt_r;
  logic                   busy_r;
  logic                   done_r;

  // Restoring remainder over the top byte: shift in a bit, subtract if not below.
  always_comb begin
    logic [TW-1:0] t;
    logic [RW-1:0] r;
    r = rem_r;
    for (int i = 0; i < HASH_DIGIT_W; i++) begin
      t = {r, key_sh_r[KEY_W-1-i]};
      if (t >= MODULUS) begin
        t = t - MODULUS;
      end
      r = t[RW-1:0];
    end
    rem_nxt = r;
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      digit_cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r      <= 1'b1;
        digit_cnt_r <= '0;
      end else if (busy_r) begin
        digit_cnt_r <= digit_cnt_r + DIGIT_CNT_W'(1);
        if (digit_cnt_r == LAST_DIGIT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Key shifter and partial remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      key_sh_r <= key;
      rem_r    <= '0;
    end else if (busy_r) begin
      key_sh_r <= key_sh_r << HASH_DIGIT_W;
      rem_r    <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== src/bht_store.sv =====
// Stored keys and per-bucket valid rows, with a clearing pass after reset.
`timescale 1ns / 1ps
module bht_store #(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS = 8,
  localparam int BKW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bht_pkg::bht_mem_ctl_t     ctl,
  input  logic [BKW-1:0]            bucket,
  input  logic [WW-1:0]             rd_way,
  input  logic [WW-1:0]             wr_way,
  input  logic [bht_pkg::KEY_W-1:0] wr_key,
  input  logic [WAYS-1:0]           wr_row,
  output logic [bht_pkg::KEY_W-1:0] key_rd,
  output logic [WAYS-1:0]           row_rd,
  output logic                      clr_busy
);
  import bht_pkg::*;

  localparam logic [BKW-1:0] LAST_BUCKET = BKW'(NUM_BUCKETS - 1);

  logic [KEY_W-1:0] key_mem [NUM_BUCKETS][WAYS];
  logic [WAYS-1:0]  row_mem [NUM_BUCKETS];
  logic [KEY_W-1:0] key_rd_r;
  logic [WAYS-1:0]  row_rd_r;
  logic             clr_busy_r;
  logic [BKW-1:0]   clr_idx_r;

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.key_wr_en) begin
      key_mem[bucket][wr_way] <= wr_key;
    end
    if (ctl.rd_en) begin
      key_rd_r <= key_mem[bucket][rd_way];
    end
  end

  // Valid row memory; the clearing pass owns the write port while it runs.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      row_mem[clr_idx_r] <= '0;
    end else if (ctl.row_wr_en) begin
      row_mem[bucket] <= wr_row;
    end
    if (ctl.rd_en) begin
      row_rd_r <= row_mem[bucket];
    end
  end

  // Clearing pass: one bucket row per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + BKW'(1);
      if (clr_idx_r == LAST_BUCKET) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign key_rd   = key_rd_r;
  assign row_rd   = row_rd_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== tb/bucketed_hash_key_table_test.sv =====
// Self-checking testbench for the bucketed hash key table: predicts every result beat.
`timescale 1ns / 1ps
module bucketed_hash_key_table_test;
  import bht_pkg::*;

  localparam int NUM_BUCKETS = 16;
  localparam int WAYS = 8;
  localparam int SLOTS = NUM_BUCKETS * WAYS;
  localparam int RANDOM_REQUESTS = 1428;
  localparam int POOL_KEYS = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;

  // The spare mode code acts as a get.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Gap pattern on the two channels.
  typedef enum logic [1:0] {
    PH_SENDER_GAPS,
    PH_RECEIVER_GAPS,
    PH_NO_GAPS
  } gap_phase_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0] key;
    gap_phase_t phase;
    bit drain;
  } table_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BUCKET_IDX_W-1:0] bucket;
    logic [WAY_IDX_W-1:0] way;
    logic [TOTAL_W-1:0] total;
  } table_reply_t;

  logic clk;
  logic rst_n;

  bht_req_if req_bus ();
  bht_rsp_if rsp_bus ();

  bucketed_hash_key_table #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS(WAYS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(req_bus),
    .out_bus(rsp_bus)
  );

  // Predicted table contents.
  logic [KEY_W-1:0] key_store [SLOTS];
  bit slot_used [SLOTS];
  int unsigned live_count;

  table_request_t request_q[$];
  table_reply_t pending_replies[$];
  logic [KEY_W-1:0] key_pool [NUM_BUCKETS][POOL_KEYS];

  gap_phase_t cur_phase;
  logic in_fired;
  int unsigned accepted_beats;
  int unsigned queued_total;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Applies one request to the predicted table and returns its reply.
  function automatic table_reply_t apply_table_request(logic [MODE_W-1:0] mode,
                                                       logic [KEY_W-1:0] key);
    table_reply_t reply;
    int unsigned bucket;
    int hit;
    int free_slot;
    bucket = key % NUM_BUCKETS;
    hit = -1;
    free_slot = -1;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (slot_used[bucket * WAYS + w] && key_store[bucket * WAYS + w] == key) hit = w;
      if (!slot_used[bucket * WAYS + w]) free_slot = w;
    end
    reply.way = '0;
    case (mode)
      MODE_CREATE: begin
        if (hit >= 0) begin
          reply.status = STAT_FOUND;
          reply.way = hit[WAY_IDX_W-1:0];
        end else if (free_slot >= 0) begin
          key_store[bucket * WAYS + free_slot] = key;
          slot_used[bucket * WAYS + free_slot] = 1'b1;
          live_count++;
          reply.status = STAT_INSERTED;
          reply.way = free_slot[WAY_IDX_W-1:0];
        end else begin
          reply.status = STAT_FULL;
        end
      end
      MODE_DELETE: begin
        if (hit >= 0) begin
          slot_used[bucket * WAYS + hit] = 1'b0;
          if (live_count > 0) live_count--;
          reply.status = STAT_DELETED;
          reply.way = hit[WAY_IDX_W-1:0];
        end else begin
          reply.status = STAT_ABSENT;
        end
      end
      default: begin
        if (hit >= 0) begin
          reply.status = STAT_FOUND;
          reply.way = hit[WAY_IDX_W-1:0];
        end else begin
          reply.status = STAT_ABSENT;
        end
      end
    endcase
    reply.bucket = bucket[BUCKET_IDX_W-1:0];
    reply.total = live_count[TOTAL_W-1:0];
    return reply;
  endfunction

  task automatic queue_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               gap_phase_t phase, bit drain);
    table_request_t item;
    item.mode = mode;
    item.key = key;
    item.phase = phase;
    item.drain = drain;
    request_q.push_back(item);
    queued_total++;
  endtask

  // Mostly keys from a small pool per bucket so that hits and full buckets occur.
  function automatic logic [MODE_W-1:0] pick_mode();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return MODE_CREATE;
    if (roll < 70) return MODE_GET;
    if (roll < 95) return MODE_DELETE;
    return MODE_SPARE;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 10) return $urandom();
    return key_pool[$urandom_range(NUM_BUCKETS - 1)][$urandom_range(POOL_KEYS - 1)];
  endfunction

  // Clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Request driver: presents the next queued beat at the falling edge.
  always @(negedge clk) begin : drive_requests
    logic next_valid;
    logic [MODE_W-1:0] next_mode;
    logic [KEY_W-1:0] next_key;
    int unsigned idle_pct;
    next_valid = req_bus.valid;
    next_mode = req_bus.mode;
    next_key = req_bus.key;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!req_bus.valid || in_fired) begin
      next_valid = 1'b0;
      if (request_q.size() != 0) begin
        case (request_q[0].phase)
          PH_SENDER_GAPS: idle_pct = 31;
          PH_RECEIVER_GAPS: idle_pct = 50;
          default: idle_pct = 0;
        endcase
        cur_phase <= request_q[0].phase;
        if (request_q[0].drain && pending_replies.size() != 0) begin
          next_valid = 1'b0;
        end else if ($urandom_range(99) >= idle_pct) begin
          next_valid = 1'b1;
          next_mode = request_q[0].mode;
          next_key = request_q[0].key;
          void'(request_q.pop_front());
        end
      end
    end
    req_bus.valid <= next_valid;
    req_bus.mode <= next_mode;
    req_bus.key <= next_key;
  end

  // Result receiver: random back-pressure per phase.
  always @(negedge clk) begin : drive_ready
    int unsigned stall_pct;
    case (cur_phase)
      PH_SENDER_GAPS: stall_pct = 50;
      PH_RECEIVER_GAPS: stall_pct = 31;
      default: stall_pct = 0;
    endcase
    if (!rst_n) rsp_bus.ready <= 1'b0;
    else rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: checks result beats first, then predicts accepted request beats.
  always @(posedge clk) begin : watch_channels
    table_reply_t seen;
    table_reply_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (rst_n) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        seen.status = rsp_bus.status;
        seen.bucket = rsp_bus.bucket_index;
        seen.way = rsp_bus.way_index;
        seen.total = rsp_bus.entry_total;
        if (pending_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("Unexpected result beat: status %0d bucket %0d way %0d total %0d",
                     seen.status, seen.bucket, seen.way, seen.total);
        end else begin
          want = pending_replies.pop_front();
          if (seen.status !== want.status || seen.bucket !== want.bucket ||
              seen.way !== want.way || seen.total !== want.total) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("Result mismatch: expected status %0d bucket %0d way %0d total %0d, %s",
                       want.status, want.bucket, want.way, want.total,
                       $sformatf("got status %0d bucket %0d way %0d total %0d",
                                 seen.status, seen.bucket, seen.way, seen.total));
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        pending_replies.push_back(apply_table_request(req_bus.mode, req_bus.key));
        accepted_beats <= accepted_beats + 1;
      end
      in_fired <= req_bus.valid && req_bus.ready;
    end else begin
      in_fired <= 1'b0;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    gap_phase_t phase;
    req_bus.valid = 1'b0;
    req_bus.mode = MODE_CREATE;
    req_bus.key = '0;
    rsp_bus.ready = 1'b0;
    rst_n = 1'b0;
    cur_phase = PH_SENDER_GAPS;
    in_fired = 1'b0;
    accepted_beats = 0;
    queued_total = 0;
    mismatch_count = 0;
    cycle_count = 0;
    live_count = 0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s] = 1'b0;
      key_store[s] = '0;
    end
    for (int b = 0; b < NUM_BUCKETS; b++)
      for (int j = 0; j < POOL_KEYS; j++)
        key_pool[b][j] = {28'($urandom() >> 4), 4'(b)};

    // Directed part: empty table, extreme keys, filling bucket zero, all modes.
    queue_request(MODE_GET, 32'h0000_0000, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_DELETE, 32'hFFFF_FFFF, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_CREATE, 32'h0000_0000, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_CREATE, 32'h0000_0000, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_SPARE, 32'h0000_0000, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_CREATE, 32'hFFFF_FFFF, PH_SENDER_GAPS, 1'b0);
    for (int i = 1; i < WAYS; i++)
      queue_request(MODE_CREATE, 32'(i * NUM_BUCKETS), PH_SENDER_GAPS, 1'b0);
    // Bucket zero is now full.
    queue_request(MODE_CREATE, 32'h8000_0000, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_DELETE, 32'h0000_0000, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_CREATE, 32'h8000_0000, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_GET, 32'h8000_0000, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_DELETE, 32'hFFFF_FFFF, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_GET, 32'hFFFF_FFFF, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_SPARE, 32'h1234_5678, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_CREATE, 32'hAAAA_AAAA, PH_SENDER_GAPS, 1'b0);
    queue_request(MODE_CREATE, 32'h5555_5555, PH_SENDER_GAPS, 1'b0);

    // Random part in three gap phases; the sender drains at each phase start.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i < RANDOM_REQUESTS / 3) phase = PH_SENDER_GAPS;
      else if (i < 2 * RANDOM_REQUESTS / 3) phase = PH_RECEIVER_GAPS;
      else phase = PH_NO_GAPS;
      queue_request(pick_mode(), pick_key(), phase, (i % (RANDOM_REQUESTS / 3)) == 0);
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    while (accepted_beats != queued_total || pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/bht_pkg.sv
src/bht_if.sv
src/bht_mod_unit.sv
src/bht_store.sv
src/bucketed_hash_key_table.sv
tb/bucketed_hash_key_table_test.sv
